FILE: rtl/ddfp_pkg.sv
// shared types and constants for the delimited decimal frame parser
package ddfp_pkg;

  localparam logic [7:0] CH_START   = 8'h24;
  localparam logic [7:0] CH_BOUND   = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam int unsigned OUT_W       = 16;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned EXT_W       = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned LVL_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] LAST_FIELD = 2'd2;

  typedef enum logic [2:0] {
    OP_START,
    OP_BOUND,
    OP_DIGIT,
    OP_NEWLINE,
    OP_OTHER
  } ddfp_op_e;

  typedef struct packed {
    ddfp_op_e   op;
    logic [3:0] digit;
  } ddfp_cmd_t;

endpackage

FILE: rtl/ddfp_front.sv
// input side: takes received bytes and classifies them into commands
module ddfp_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output ddfp_pkg::ddfp_cmd_t cmd_o,
  input  logic               full_i
);
  import ddfp_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.digit = 4'd0;
    if (rx_byte_i == CH_NEWLINE) begin
      cmd_o.op = OP_NEWLINE;
    end else if (rx_byte_i == CH_START) begin
      cmd_o.op = OP_START;
    end else if (rx_byte_i == CH_BOUND) begin
      cmd_o.op = OP_BOUND;
    end else if (rx_byte_i >= CH_ZERO && rx_byte_i <= CH_NINE) begin
      cmd_o.op    = OP_DIGIT;
      cmd_o.digit = rx_byte_i[3:0];
    end else begin
      cmd_o.op = OP_OTHER;
    end
  end

endmodule

FILE: rtl/ddfp_queue.sv
// short command queue between the classifier and the executor
module ddfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ddfp_pkg::ddfp_cmd_t push_cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output ddfp_pkg::ddfp_cmd_t cmd_o,
  input  logic                pop_i
);
  import ddfp_pkg::*;

  ddfp_cmd_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0]  level_q, level_d;

  assign full_o  = (level_q == LVL_W'(QUEUE_DEPTH));
  assign valid_o = (level_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LVL_W'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/ddfp_back.sv
// executor: field accumulation, boundary tracking and the result register
module ddfp_back #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  ddfp_pkg::ddfp_cmd_t            cmd_i,
  output logic                           cmd_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ddfp_pkg::OUT_W-1:0]     first_value_o,
  output logic [ddfp_pkg::OUT_W-1:0]     second_value_o,
  output logic [ddfp_pkg::OUT_W-1:0]     third_value_o,
  output logic [ddfp_pkg::CNT_W-1:0]     boundaries_seen_o
);
  import ddfp_pkg::*;

  localparam int unsigned PW = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] vals_q [3];
  logic [VALUE_BITS-1:0] vals_d [3];
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  started_q, started_d;
  logic                  stopped_q, stopped_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      first_q, first_d;
  logic [OUT_W-1:0]      second_q, second_d;
  logic [OUT_W-1:0]      third_q, third_d;
  logic [CNT_W-1:0]      bounds_q, bounds_d;
  logic                  slot_free;
  logic                  pop_nl;
  logic [VALUE_BITS-1:0] cur_val;
  logic [PW-1:0]         prod;

  function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_BITS-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return ext[OUT_W-1:0];
  endfunction

  assign slot_free = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = cmd_valid_i && (cmd_i.op != OP_NEWLINE || slot_free);
  assign pop_nl    = cmd_pop_o && (cmd_i.op == OP_NEWLINE);
  assign cur_val   = vals_q[idx_q];
  assign prod      = PW'({cur_val, 3'b000}) + PW'({cur_val, 1'b0}) + PW'(cmd_i.digit);

  always_comb begin
    vals_d      = vals_q;
    idx_d       = idx_q;
    started_d   = started_q;
    stopped_d   = stopped_q;
    out_valid_d = out_valid_q && out_stall_i;
    first_d     = first_q;
    second_d    = second_q;
    third_d     = third_q;
    bounds_d    = bounds_q;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_NEWLINE: begin
          out_valid_d = 1'b1;
          first_d     = (idx_q != '0) ? to_out(vals_q[0]) : '0;
          second_d    = (idx_q == LAST_FIELD) ? to_out(vals_q[1]) : '0;
          third_d     = (idx_q == LAST_FIELD) ? to_out(vals_q[2]) : '0;
          bounds_d    = idx_q;
          vals_d[0]   = '0;
          vals_d[1]   = '0;
          vals_d[2]   = '0;
          idx_d       = '0;
          started_d   = 1'b0;
          stopped_d   = 1'b0;
        end
        OP_START: begin
          started_d = 1'b1;
        end
        OP_BOUND: begin
          if (started_q && idx_q < LAST_FIELD) begin
            idx_d     = idx_q + CNT_W'(1);
            stopped_d = 1'b0;
          end
        end
        OP_DIGIT: begin
          if (!stopped_q) begin
            vals_d[idx_q] = prod[VALUE_BITS-1:0];
          end
        end
        OP_OTHER: begin
          stopped_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vals_q[0]   <= '0;
      vals_q[1]   <= '0;
      vals_q[2]   <= '0;
      idx_q       <= '0;
      started_q   <= 1'b0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vals_q      <= vals_d;
      idx_q       <= idx_d;
      started_q   <= started_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    third_q  <= third_d;
    bounds_q <= bounds_d;
  end

  assign out_valid_o       = out_valid_q;
  assign first_value_o     = first_q;
  assign second_value_o    = second_q;
  assign third_value_o     = third_q;
  assign boundaries_seen_o = bounds_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_FIELD)
    else $error("field index beyond last field");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_nl && out_valid_q && out_stall_i))
    else $error("newline executed while result register blocked");

  a_clear_after_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_nl |=> (idx_q == '0 && !started_q && !stopped_q && out_valid_q))
    else $error("frame state not cleared after newline");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_nl))
    else $error("result appeared without a newline");

  a_bounds_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_nl |=> (bounds_q == $past(idx_q)))
    else $error("boundary count not taken from field index");

endmodule

FILE: rtl/delimited_decimal_frame_parser.sv
// top level of the delimited decimal frame parser
// Accepts one received byte per cycle while in_stall_o is low and reports, for each
// newline, the three decimal fields of a $a#$b#$c# frame and the number of '#' counted
// after a '$', at most two. Bytes are classified on entry and written to a four-entry
// command queue; the executor drains one command per cycle, so sustained throughput is
// one byte per cycle. A newline is written into the queue, then executed into the
// output register that holds the result. The executor waits only on a newline while
// the previous result is still stalled; input stall rises only once the queue is full.
module delimited_decimal_frame_parser #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ddfp_pkg::OUT_W-1:0] first_value_o,
  output logic [ddfp_pkg::OUT_W-1:0] second_value_o,
  output logic [ddfp_pkg::OUT_W-1:0] third_value_o,
  output logic [ddfp_pkg::CNT_W-1:0] boundaries_seen_o
);
  import ddfp_pkg::*;

  logic      push;
  logic      full;
  ddfp_cmd_t push_cmd;
  logic      q_valid;
  ddfp_cmd_t q_cmd;
  logic      pop;

  ddfp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  ddfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd),
    .pop_i      (pop)
  );

  ddfp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (q_valid),
    .cmd_i             (q_cmd),
    .cmd_pop_o         (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .first_value_o     (first_value_o),
    .second_value_o    (second_value_o),
    .third_value_o     (third_value_o),
    .boundaries_seen_o (boundaries_seen_o)
  );

endmodule

FILE: tb/delimited_decimal_frame_parser_test.sv
// testbench for the delimited decimal frame parser: directed and random frames, checked per field
`timescale 1ns / 100ps

module delimited_decimal_frame_parser_test;
  import ddfp_pkg::*;

  localparam int unsigned VALUE_BITS     = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [7:0]  CH_RETURN      = 8'h0D;
  localparam logic [7:0]  CH_HIGH        = 8'hFF;

  typedef struct packed {
    logic [OUT_W-1:0] first;
    logic [OUT_W-1:0] second;
    logic [OUT_W-1:0] third;
    logic [CNT_W-1:0] bounds;
  } frame_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       rx_byte_i = 8'h00;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [OUT_W-1:0] first_value_o;
  logic [OUT_W-1:0] second_value_o;
  logic [OUT_W-1:0] third_value_o;
  logic [CNT_W-1:0] boundaries_seen_o;

  // parser state mirror
  logic [VALUE_BITS-1:0] field_vals [3] = '{default: '0};
  logic [CNT_W-1:0]      field_idx = '0;
  logic                  frame_started = 1'b0;
  logic                  digits_stopped = 1'b0;

  frame_t      expected_frames [$];
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  bit          idle_en = 1'b1;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  delimited_decimal_frame_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .first_value_o    (first_value_o),
    .second_value_o   (second_value_o),
    .third_value_o    (third_value_o),
    .boundaries_seen_o(boundaries_seen_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit parse_byte(input logic [7:0] b, output frame_t res);
    logic [VALUE_BITS+3:0] wide;
    res = '0;
    if (b == CH_NEWLINE) begin
      if (field_idx >= 1) res.first = OUT_W'(field_vals[0]);
      if (field_idx >= 2) begin
        res.second = OUT_W'(field_vals[1]);
        res.third  = OUT_W'(field_vals[2]);
      end
      res.bounds = field_idx;
      field_vals = '{default: '0};
      field_idx = '0;
      frame_started = 1'b0;
      digits_stopped = 1'b0;
      return 1'b1;
    end
    if (b == CH_START) begin
      frame_started = 1'b1;
    end else if (b == CH_BOUND) begin
      if (frame_started && field_idx < LAST_FIELD) begin
        field_idx = field_idx + 1'b1;
        digits_stopped = 1'b0;
      end
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (!digits_stopped) begin
        wide = (VALUE_BITS+4)'(field_vals[field_idx] * 10 + (b - CH_ZERO));
        field_vals[field_idx] = wide[VALUE_BITS-1:0];
      end
    end else begin
      digits_stopped = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic note_error(input string what, input frame_t want, input frame_t seen);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s: expected %0d %0d %0d /%0d, got %0d %0d %0d /%0d", $realtime, what,
               want.first, want.second, want.third, want.bounds,
               seen.first, seen.second, seen.third, seen.bounds);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    frame_t res;
    while (idle_en && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_byte(b, res)) expected_frames.push_back(res);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    int unsigned n_bounds;
    int unsigned n_digits;
    logic [7:0]  junk;
    n_bounds = ($urandom_range(0, 9) < 6) ? 3 : $urandom_range(0, 2);
    for (int f = 0; f < 3; f++) begin
      if ($urandom_range(0, 9) != 0) send_byte(CH_START);
      n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      repeat (n_digits) send_byte(rand_digit());
      if ($urandom_range(0, 9) == 0) begin
        do junk = 8'($urandom_range(0, 255)); while (junk == CH_NEWLINE);
        send_byte(junk);
        repeat ($urandom_range(0, 2)) send_byte(rand_digit());
      end
      if (f >= n_bounds) break;
      send_byte(CH_BOUND);
      if (f == 2 && $urandom_range(0, 3) == 0) send_byte(CH_BOUND);
    end
    if ($urandom_range(0, 7) == 0) send_byte(CH_RETURN);
    send_byte(CH_NEWLINE);
  endtask

  task automatic test_directed();
    logic [7:0] seq [$];
    // empty frame, boundary before start, digits before start, stop byte, wrap,
    // extra boundaries, carriage return, single closed field
    seq = '{CH_NEWLINE, CH_BOUND, "1", "2", CH_START, CH_HIGH, "7", CH_BOUND,
            "6", "5", "5", "3", "5", CH_BOUND, "9", "9", "9", "9", "9", CH_BOUND, CH_BOUND,
            CH_RETURN, CH_NEWLINE, "9", CH_START, CH_BOUND, CH_NEWLINE};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_drain_pause();
    repeat (4) send_frame();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (4) send_frame();
  endtask

  task automatic test_random_frames();
    while (bytes_sent < 500) send_frame();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    while (bytes_sent < 650) send_frame();
    idle_en = 1'b1;
  endtask

  task automatic test_noise();
    repeat (150)
      send_byte(($urandom_range(0, 15) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255)));
    send_byte(CH_NEWLINE);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= idle_en && ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_t seen;
    frame_t want;
    if (rst_ni && out_fire) begin
      seen = '{first_value_o, second_value_o, third_value_o, boundaries_seen_o};
      if (expected_frames.size() == 0) begin
        note_error("unexpected result", seen, seen);
      end else begin
        want = expected_frames.pop_front();
        if (seen.first !== want.first || seen.second !== want.second ||
            seen.third !== want.third || seen.bounds !== want.bounds)
          note_error("field mismatch", want, seen);
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("delimited_decimal_frame_parser_test: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_drain_pause();
    test_random_frames();
    test_back_to_back();
    test_noise();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("delimited_decimal_frame_parser_test: clean");
    end else begin
      $display("delimited_decimal_frame_parser_test: errors");
    end
    $finish;
  end

endmodule
